// ===== sv/cbpc_pkg.sv =====
// ----------------------------------------------------------------------------
// cbpc_pkg
// Shared constants, micro-operation codes and the step program of the
// cascaded balance controller.
// ----------------------------------------------------------------------------
package cbpc_pkg;

  localparam int SIGNAL_FRAC_BITS_DEF = 16;
  localparam int GAIN_FRAC_BITS_DEF   = 20;
  localparam int WORD_WIDTH_DEF       = 32;

  localparam int BLEND_FRAC = 16;
  localparam int W98 = 64225;
  localparam int W02 = 1311;
  localparam int W70 = 45875;
  localparam int W30 = 19661;

  localparam int NUM_REGS = 8;
  localparam int CFG_AW   = 5;

  localparam logic [2:0] REG_ANGLE_KP   = 3'd0;
  localparam logic [2:0] REG_ANGLE_KI   = 3'd1;
  localparam logic [2:0] REG_ANGLE_KD   = 3'd2;
  localparam logic [2:0] REG_SPEED_KP   = 3'd3;
  localparam logic [2:0] REG_TURN_KP    = 3'd4;
  localparam logic [2:0] REG_TILT_OFS   = 3'd5;
  localparam logic [2:0] REG_PITCH_BIAS = 3'd6;
  localparam logic [2:0] REG_YAW_BIAS   = 3'd7;

  localparam logic [31:0] CFG_RESET [NUM_REGS] = '{
    32'd1937768448, 32'd0, 32'd20971520, 32'hFFFF_F7CF,
    32'd52428800, 32'd8258, 32'd2294, 32'd9503
  };

  typedef logic [2:0] op_t;
  localparam op_t OP_ADD  = 3'd0;
  localparam op_t OP_SUB  = 3'd1;
  localparam op_t OP_CLMP = 3'd2;
  localparam op_t OP_MULB = 3'd3;  // product, rounded shift by the blend fraction
  localparam op_t OP_MULG = 3'd4;  // product, rounded shift by the gain fraction
  localparam op_t OP_MDIV = 3'd5;  // exact product, then rounded division

  typedef logic [5:0] src_t;
  localparam src_t SRC_X0    = 6'd0;
  localparam src_t SRC_X1    = 6'd1;
  localparam src_t SRC_X2    = 6'd2;
  localparam src_t SRC_X3    = 6'd3;
  localparam src_t SRC_TILT  = 6'd4;
  localparam src_t SRC_PTT   = 6'd5;
  localparam src_t SRC_INTEG = 6'd6;
  localparam src_t SRC_PERR  = 6'd7;
  localparam src_t SRC_PDRV  = 6'd8;
  localparam src_t SRC_PTURN = 6'd9;
  localparam src_t SRC_ACCEL = 6'd10;
  localparam src_t SRC_PITCH = 6'd11;
  localparam src_t SRC_YAW   = 6'd12;
  localparam src_t SRC_WHEEL = 6'd13;
  localparam src_t SRC_TSPD  = 6'd14;
  localparam src_t SRC_TYR   = 6'd15;
  localparam src_t SRC_BIAS6 = 6'd16;
  localparam src_t SRC_BIAS7 = 6'd17;
  localparam src_t SRC_OFFS  = 6'd18;
  localparam src_t SRC_KP    = 6'd19;
  localparam src_t SRC_KI    = 6'd20;
  localparam src_t SRC_KD    = 6'd21;
  localparam src_t SRC_SPKP  = 6'd22;
  localparam src_t SRC_TKP   = 6'd23;
  localparam src_t SRC_MS    = 6'd24;
  localparam src_t SRC_K1000 = 6'd25;
  localparam src_t SRC_W98   = 6'd26;
  localparam src_t SRC_W02   = 6'd27;
  localparam src_t SRC_W70   = 6'd28;
  localparam src_t SRC_W30   = 6'd29;
  localparam src_t SRC_B300  = 6'd30;
  localparam src_t SRC_B120  = 6'd31;
  localparam src_t SRC_ZERO  = 6'd32;

  typedef logic [3:0] dst_t;
  localparam dst_t DST_X0    = 4'd0;
  localparam dst_t DST_X1    = 4'd1;
  localparam dst_t DST_X2    = 4'd2;
  localparam dst_t DST_X3    = 4'd3;
  localparam dst_t DST_TILT  = 4'd4;
  localparam dst_t DST_PTT   = 4'd5;
  localparam dst_t DST_INTEG = 4'd6;
  localparam dst_t DST_PERR  = 4'd7;
  localparam dst_t DST_PDRV  = 4'd8;
  localparam dst_t DST_PTURN = 4'd9;

  typedef struct packed {
    op_t  op;
    src_t a;
    src_t b;
    dst_t dst;
  } uop_t;

  localparam int NSTEPS = 36;
  localparam logic [5:0] LAST_STEP = 6'(NSTEPS - 1);

  function automatic uop_t cbpc_ucode(input logic [5:0] step);
    uop_t u;
    u = '{OP_ADD, SRC_ZERO, SRC_ZERO, DST_X0};
    case (step)
      6'd0:  u = '{OP_SUB,  SRC_PITCH, SRC_BIAS6, DST_X0};
      6'd1:  u = '{OP_MDIV, SRC_X0,    SRC_MS,    DST_X0};
      6'd2:  u = '{OP_ADD,  SRC_TILT,  SRC_X0,    DST_X1};
      6'd3:  u = '{OP_MULB, SRC_X1,    SRC_W98,   DST_X1};
      6'd4:  u = '{OP_MULB, SRC_ACCEL, SRC_W02,   DST_X2};
      6'd5:  u = '{OP_ADD,  SRC_X1,    SRC_X2,    DST_TILT};
      6'd6:  u = '{OP_ADD,  SRC_TSPD,  SRC_WHEEL, DST_X0};
      6'd7:  u = '{OP_MULG, SRC_SPKP,  SRC_X0,    DST_X0};
      6'd8:  u = '{OP_ADD,  SRC_X0,    SRC_OFFS,  DST_X0};
      6'd9:  u = '{OP_MULB, SRC_X0,    SRC_W70,   DST_X0};
      6'd10: u = '{OP_MULB, SRC_PTT,   SRC_W30,   DST_X1};
      6'd11: u = '{OP_ADD,  SRC_X0,    SRC_X1,    DST_PTT};
      6'd12: u = '{OP_SUB,  SRC_PTT,   SRC_TILT,  DST_X3};
      6'd13: u = '{OP_MDIV, SRC_X3,    SRC_MS,    DST_X0};
      6'd14: u = '{OP_ADD,  SRC_INTEG, SRC_X0,    DST_X0};
      6'd15: u = '{OP_CLMP, SRC_X0,    SRC_B300,  DST_INTEG};
      6'd16: u = '{OP_SUB,  SRC_X3,    SRC_PERR,  DST_X0};
      6'd17: u = '{OP_MDIV, SRC_X0,    SRC_K1000, DST_X0};
      6'd18: u = '{OP_MULG, SRC_KP,    SRC_X3,    DST_X1};
      6'd19: u = '{OP_MULG, SRC_KI,    SRC_INTEG, DST_X2};
      6'd20: u = '{OP_ADD,  SRC_X1,    SRC_X2,    DST_X1};
      6'd21: u = '{OP_MULG, SRC_KD,    SRC_X0,    DST_X0};
      6'd22: u = '{OP_ADD,  SRC_X1,    SRC_X0,    DST_X0};
      6'd23: u = '{OP_MULB, SRC_X0,    SRC_W70,   DST_X0};
      6'd24: u = '{OP_MULB, SRC_PDRV,  SRC_W30,   DST_X1};
      6'd25: u = '{OP_ADD,  SRC_X0,    SRC_X1,    DST_PDRV};
      6'd26: u = '{OP_ADD,  SRC_X3,    SRC_ZERO,  DST_PERR};
      6'd27: u = '{OP_SUB,  SRC_YAW,   SRC_BIAS7, DST_X0};
      6'd28: u = '{OP_SUB,  SRC_TYR,   SRC_X0,    DST_X0};
      6'd29: u = '{OP_MULG, SRC_TKP,   SRC_X0,    DST_X0};
      6'd30: u = '{OP_MULB, SRC_X0,    SRC_W70,   DST_X0};
      6'd31: u = '{OP_MULB, SRC_PTURN, SRC_W30,   DST_X1};
      6'd32: u = '{OP_ADD,  SRC_X0,    SRC_X1,    DST_PTURN};
      6'd33: u = '{OP_CLMP, SRC_PDRV,  SRC_B120,  DST_X0};
      6'd34: u = '{OP_ADD,  SRC_X0,    SRC_PTURN, DST_X1};
      6'd35: u = '{OP_SUB,  SRC_X0,    SRC_PTURN, DST_X2};
      default: u = '{OP_ADD, SRC_ZERO, SRC_ZERO, DST_X0};
    endcase
    return u;
  endfunction

endpackage

// ===== sv/cbpc_if.sv =====
// ----------------------------------------------------------------------------
// cbpc_if
// Valid/ready channels of the balance controller: sensor word in, drive
// word out.
// ----------------------------------------------------------------------------
interface cbpc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] accel_tilt;
  logic signed [31:0] pitch_rate;
  logic signed [31:0] yaw_rate;
  logic signed [31:0] wheel_speed;
  logic signed [31:0] target_speed;
  logic signed [31:0] target_yaw_rate;
  logic        [9:0]  elapsed_ms;

  modport source (output valid, accel_tilt, pitch_rate, yaw_rate, wheel_speed,
                  target_speed, target_yaw_rate, elapsed_ms, input ready);
  modport sink (input valid, accel_tilt, pitch_rate, yaw_rate, wheel_speed,
                target_speed, target_yaw_rate, elapsed_ms, output ready);
endinterface

interface cbpc_out_if;
  logic               valid;
  logic               ready;
  logic        [30:0] right_accel;
  logic        [30:0] left_accel;
  logic               right_reverse;
  logic               left_forward;
  logic signed [31:0] tilt_estimate;

  modport source (output valid, right_accel, left_accel, right_reverse,
                  left_forward, tilt_estimate, input ready);
  modport sink (input valid, right_accel, left_accel, right_reverse,
                left_forward, tilt_estimate, output ready);
endinterface

// ===== sv/cascaded_balance_pid_controller.sv =====
// ----------------------------------------------------------------------------
// cascaded_balance_pid_controller
// Complementary tilt filter, speed loop, tilt PID and yaw term for a
// two-wheeled balancing robot, computed by a bit-serial sequencer.
// ----------------------------------------------------------------------------
// One sensor word is processed at a time. A 36-step program runs through a
// shared bit-serial multiplier (one multiplier bit per cycle) and a restoring
// divider (one quotient bit per cycle). The input is ready whenever the
// sequencer is idle, and a finished result waits in the output register
// while the next word is being worked on.
module cascaded_balance_pid_controller #(
  parameter int SIGNAL_FRAC_BITS = cbpc_pkg::SIGNAL_FRAC_BITS_DEF,
  parameter int GAIN_FRAC_BITS   = cbpc_pkg::GAIN_FRAC_BITS_DEF,
  parameter int WORD_WIDTH       = cbpc_pkg::WORD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  cbpc_in_if.sink                     in_chan,
  cbpc_out_if.source                  out_chan,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [cbpc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import cbpc_pkg::*;

  localparam int MW = (WORD_WIDTH > 32) ? WORD_WIDTH : 32;
  localparam int PW = 2 * MW;
  localparam int DW = MW + 11;
  localparam int CW = $clog2(DW + 1);

  typedef logic signed [WORD_WIDTH-1:0] word_t;
  typedef logic signed [MW-1:0] opnd_t;

  localparam word_t W_HI = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam word_t W_LO = {1'b1, {(WORD_WIDTH-1){1'b0}}};
  localparam longint HI_L   = (longint'(1) <<< (WORD_WIDTH - 1)) - 1;
  localparam longint B300_L = ((longint'(300) <<< SIGNAL_FRAC_BITS) > HI_L) ? HI_L
                              : (longint'(300) <<< SIGNAL_FRAC_BITS);
  localparam longint B120_L = ((longint'(120) <<< SIGNAL_FRAC_BITS) > HI_L) ? HI_L
                              : (longint'(120) <<< SIGNAL_FRAC_BITS);
  localparam word_t B300 = WORD_WIDTH'(B300_L);
  localparam word_t B120 = WORD_WIDTH'(B120_L);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DWR  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  function automatic word_t sat_w(input logic signed [MW:0] v);
    if ((&v[MW:WORD_WIDTH-1]) || !(|v[MW:WORD_WIDTH-1])) begin
      return v[WORD_WIDTH-1:0];
    end
    return v[MW] ? W_LO : W_HI;
  endfunction

  function automatic word_t sat_in(input logic signed [31:0] v);
    return sat_w((MW+1)'(v));
  endfunction

  // Signed result from a magnitude and a sign, saturated to the word.
  function automatic word_t sat_mag(input logic [PW-1:0] q, input logic neg);
    logic big;
    big = |q[PW-1:WORD_WIDTH-1];
    if (!neg) begin
      return big ? W_HI : word_t'(q[WORD_WIDTH-1:0]);
    end
    if (big && (q != (PW'(1) << (WORD_WIDTH - 1)))) begin
      return W_LO;
    end
    return word_t'(-q[WORD_WIDTH-1:0]);
  endfunction

  function automatic logic [30:0] abs31(input word_t v);
    logic signed [63:0] s;
    logic        [63:0] m;
    s = 64'(v);
    m = (s < 0) ? 64'(-s) : 64'(s);
    return (m > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : m[30:0];
  endfunction

  function automatic logic signed [31:0] sat32(input word_t v);
    logic signed [63:0] s;
    s = 64'(v);
    if (s > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end
    if (s < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return s[31:0];
  endfunction

  // Configuration registers.
  logic [31:0] cfg_r [NUM_REGS];

  // Latched input word.
  word_t      accel_r, pitch_r, yaw_r, wheel_r, tspd_r, tyr_r;
  logic [9:0] ms_r;

  // Scratch and controller state.
  word_t x0_r, x1_r, x2_r, x3_r;
  word_t tilt_r, ptt_r, integ_r, perr_r, pdrv_r, pturn_r;

  // Sequencer and serial arithmetic unit.
  logic [2:0]    state_r;
  logic [5:0]    step_r;
  logic [CW-1:0] cnt_r;
  logic [MW-1:0] ma_r;
  logic [PW-1:0] pacc_r;
  logic [9:0]    rem_r;
  logic [9:0]    den_r;
  logic          neg_r;

  logic        out_valid_r;
  logic [30:0] right_accel_r, left_accel_r;
  logic        right_reverse_r, left_forward_r;
  logic signed [31:0] tilt_est_r;

  uop_t  uop;
  opnd_t a_v, b_v;
  logic [MW-1:0] mag_a, mag_b;
  logic signed [MW:0] alu_sum;
  word_t alu_res;
  logic [MW:0] mul_sum;
  logic [PW-1:0] mul_nxt;
  logic [PW-1:0] rounded;
  word_t mul_res, div_res;
  logic [DW-1:0] dvd;
  logic [10:0] div_t;
  logic div_ge;
  logic is_mul;
  logic wr_en;
  word_t wr_val;
  logic in_acc;
  logic out_free;

  function automatic opnd_t src_val(input src_t s);
    opnd_t v;
    case (s)
      SRC_X0:    v = MW'(x0_r);
      SRC_X1:    v = MW'(x1_r);
      SRC_X2:    v = MW'(x2_r);
      SRC_X3:    v = MW'(x3_r);
      SRC_TILT:  v = MW'(tilt_r);
      SRC_PTT:   v = MW'(ptt_r);
      SRC_INTEG: v = MW'(integ_r);
      SRC_PERR:  v = MW'(perr_r);
      SRC_PDRV:  v = MW'(pdrv_r);
      SRC_PTURN: v = MW'(pturn_r);
      SRC_ACCEL: v = MW'(accel_r);
      SRC_PITCH: v = MW'(pitch_r);
      SRC_YAW:   v = MW'(yaw_r);
      SRC_WHEEL: v = MW'(wheel_r);
      SRC_TSPD:  v = MW'(tspd_r);
      SRC_TYR:   v = MW'(tyr_r);
      SRC_BIAS6: v = MW'(sat_in(cfg_r[REG_PITCH_BIAS]));
      SRC_BIAS7: v = MW'(sat_in(cfg_r[REG_YAW_BIAS]));
      SRC_OFFS:  v = MW'(sat_in(cfg_r[REG_TILT_OFS]));
      SRC_KP:    v = MW'($signed(cfg_r[REG_ANGLE_KP]));
      SRC_KI:    v = MW'($signed(cfg_r[REG_ANGLE_KI]));
      SRC_KD:    v = MW'($signed(cfg_r[REG_ANGLE_KD]));
      SRC_SPKP:  v = MW'($signed(cfg_r[REG_SPEED_KP]));
      SRC_TKP:   v = MW'($signed(cfg_r[REG_TURN_KP]));
      SRC_MS:    v = opnd_t'({{(MW-10){1'b0}}, ms_r});
      SRC_K1000: v = opnd_t'(MW'(1000));
      SRC_W98:   v = opnd_t'(MW'(W98));
      SRC_W02:   v = opnd_t'(MW'(W02));
      SRC_W70:   v = opnd_t'(MW'(W70));
      SRC_W30:   v = opnd_t'(MW'(W30));
      SRC_B300:  v = MW'(B300);
      SRC_B120:  v = MW'(B120);
      default:   v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    uop   = cbpc_ucode(step_r);
    a_v   = src_val(uop.a);
    b_v   = src_val(uop.b);
    mag_a = a_v[MW-1] ? MW'(-a_v) : MW'(a_v);
    mag_b = b_v[MW-1] ? MW'(-b_v) : MW'(b_v);
    is_mul = (uop.op == OP_MULB) || (uop.op == OP_MULG) || (uop.op == OP_MDIV);

    if (uop.op == OP_SUB) begin
      alu_sum = (MW+1)'(a_v) - (MW+1)'(b_v);
    end else begin
      alu_sum = (MW+1)'(a_v) + (MW+1)'(b_v);
    end
    case (uop.op)
      OP_CLMP: begin
        if (a_v > b_v) begin
          alu_res = b_v[WORD_WIDTH-1:0];
        end else if (a_v < -b_v) begin
          alu_res = word_t'(-b_v[WORD_WIDTH-1:0]);
        end else begin
          alu_res = a_v[WORD_WIDTH-1:0];
        end
      end
      default: alu_res = sat_w(alu_sum);
    endcase

    // Shift-and-add: the multiplier bits sit in the low half and leave
    // on the right while the partial product grows in the high half.
    mul_sum = {1'b0, pacc_r[PW-1:MW]} + (pacc_r[0] ? {1'b0, ma_r} : '0);
    mul_nxt = {mul_sum, pacc_r[MW-1:1]};

    case (uop.op)
      OP_MULB: begin
        rounded = (pacc_r + (PW'(1) << (BLEND_FRAC - 1))) >> BLEND_FRAC;
      end
      OP_MULG: begin
        rounded = (pacc_r + (PW'(1) << (GAIN_FRAC_BITS - 1))) >> GAIN_FRAC_BITS;
      end
      default: rounded = pacc_r;
    endcase
    mul_res = sat_mag(rounded, neg_r);

    dvd     = pacc_r[DW-1:0] + DW'(den_r >> 1);
    div_t   = {rem_r, pacc_r[DW-1]};
    div_ge  = div_t >= {1'b0, den_r};
    div_res = sat_mag(PW'(pacc_r[DW-1:0]), neg_r);

    wr_en  = 1'b0;
    wr_val = alu_res;
    case (state_r)
      ST_EXEC: wr_en = !is_mul;
      ST_FIN: begin
        wr_en  = (uop.op != OP_MDIV);
        wr_val = mul_res;
      end
      ST_DWR: begin
        wr_en  = 1'b1;
        wr_val = div_res;
      end
      default: wr_en = 1'b0;
    endcase
  end

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && (state_r == ST_IDLE);
  assign out_free      = !out_valid_r || out_chan.ready;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_r[cfg_paddr[CFG_AW-1:2]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_r[i] <= CFG_RESET[i];
      end
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      cfg_r[cfg_paddr[CFG_AW-1:2]] <= cfg_pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      accel_r <= sat_in(in_chan.accel_tilt);
      pitch_r <= sat_in(in_chan.pitch_rate);
      yaw_r   <= sat_in(in_chan.yaw_rate);
      wheel_r <= sat_in(in_chan.wheel_speed);
      tspd_r  <= sat_in(in_chan.target_speed);
      tyr_r   <= sat_in(in_chan.target_yaw_rate);
      ms_r    <= (in_chan.elapsed_ms == 10'd0) ? 10'd1 : in_chan.elapsed_ms;
    end
  end

  // Result writeback; the program touches one destination per step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tilt_r  <= '0;
      ptt_r   <= '0;
      integ_r <= '0;
      perr_r  <= '0;
      pdrv_r  <= '0;
      pturn_r <= '0;
    end else if (wr_en) begin
      case (uop.dst)
        DST_X0:    x0_r    <= wr_val;
        DST_X1:    x1_r    <= wr_val;
        DST_X2:    x2_r    <= wr_val;
        DST_X3:    x3_r    <= wr_val;
        DST_TILT:  tilt_r  <= wr_val;
        DST_PTT:   ptt_r   <= wr_val;
        DST_INTEG: integ_r <= wr_val;
        DST_PERR:  perr_r  <= wr_val;
        DST_PDRV:  pdrv_r  <= wr_val;
        DST_PTURN: pturn_r <= wr_val;
        default:   x0_r    <= wr_val;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            step_r  <= '0;
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (is_mul) begin
            ma_r    <= mag_a;
            pacc_r  <= {{MW{1'b0}}, mag_b};
            neg_r   <= a_v[MW-1] ^ b_v[MW-1];
            den_r   <= (uop.b == SRC_MS) ? 10'd1000 : ms_r;
            cnt_r   <= '0;
            state_r <= ST_MUL;
          end else if (step_r == LAST_STEP) begin
            state_r <= ST_DONE;
          end else begin
            step_r <= step_r + 6'd1;
          end
        end
        ST_MUL: begin
          pacc_r <= mul_nxt;
          cnt_r  <= cnt_r + CW'(1);
          if (cnt_r == CW'(MW - 1)) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (uop.op == OP_MDIV) begin
            pacc_r  <= PW'(dvd);
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= ST_DIV;
          end else if (step_r == LAST_STEP) begin
            state_r <= ST_DONE;
          end else begin
            step_r  <= step_r + 6'd1;
            state_r <= ST_EXEC;
          end
        end
        ST_DIV: begin
          pacc_r[DW-1:0] <= {pacc_r[DW-2:0], div_ge};
          rem_r <= div_ge ? 10'(div_t - {1'b0, den_r}) : div_t[9:0];
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(DW - 1)) begin
            state_r <= ST_DWR;
          end
        end
        ST_DWR: begin
          if (step_r == LAST_STEP) begin
            state_r <= ST_DONE;
          end else begin
            step_r  <= step_r + 6'd1;
            state_r <= ST_EXEC;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      right_accel_r   <= abs31(x1_r);
      left_accel_r    <= abs31(x2_r);
      right_reverse_r <= (x1_r > 0);
      left_forward_r  <= (x2_r > 0);
      tilt_est_r      <= sat32(tilt_r);
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.right_accel   = right_accel_r;
  assign out_chan.left_accel    = left_accel_r;
  assign out_chan.right_reverse = right_reverse_r;
  assign out_chan.left_forward  = left_forward_r;
  assign out_chan.tilt_estimate = tilt_est_r;

endmodule

// ===== test/cascaded_balance_pid_controller_tb.sv =====
// ----------------------------------------------------------------------------
// cascaded_balance_pid_controller_tb
// Self-checking bench for the cascaded balance controller. Sensor words go in
// through the input channel and an in-bench copy of the fixed-point control
// law predicts every drive word. The bench runs several gain and bias
// settings, the extremes among them, with random idling on both channels.
// ----------------------------------------------------------------------------
module cascaded_balance_pid_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cbpc_pkg::*;

  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] accel_tilt, pitch_rate, yaw_rate, wheel_speed;
    logic signed [31:0] target_speed, target_yaw_rate;
    logic [9:0]         elapsed_ms;
  } sensor_word_t;

  typedef struct {
    logic [30:0]        right_accel, left_accel;
    logic               right_reverse, left_forward;
    logic signed [31:0] tilt_estimate;
  } drive_word_t;

  class balance_scoreboard;
    longint gains[NUM_REGS];
    longint tilt, ptt, integ, perr, pdrv, pturn;
    drive_word_t pending_drive[$];
    int errors;

    function new();
      for (int i = 0; i < NUM_REGS; i++) gains[i] = longint'($signed(CFG_RESET[i]));
      tilt = 0; ptt = 0; integ = 0; perr = 0; pdrv = 0; pturn = 0;
      errors = 0;
    endfunction

    function void set_reg(int idx, logic [31:0] v);
      gains[idx] = longint'($signed(v));
    endfunction

    function longint sat(longint v);
      if (v > WMAX) return WMAX;
      if (v < WMIN) return WMIN;
      return v;
    endfunction

    // Exact product, shift with rounding half away from zero.
    function longint mulshr(longint a, longint b, int sh);
      logic [127:0] p;
      logic [63:0] ua, ub;
      longint q;
      bit neg;
      neg = (a < 0) != (b < 0);
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      p = 128'(ua) * 128'(ub);
      p = (p + (128'd1 << (sh - 1))) >> sh;
      if (p > (128'd1 << 62)) p = 128'd1 << 62;
      q = longint'(p[63:0]);
      return sat(neg ? -q : q);
    endfunction

    function longint divr(longint num, longint den);
      longint u, q;
      u = num < 0 ? -num : num;
      q = (u + den / 2) / den;
      return sat(num < 0 ? -q : q);
    endfunction

    function longint blend(longint x, longint wx, longint y, longint wy);
      return sat(mulshr(x, wx, BLEND_FRAC) + mulshr(y, wy, BLEND_FRAC));
    endfunction

    function longint clampu(longint v, longint units);
      longint b;
      b = sat(units * 65536);
      if (v > b) return b;
      if (v < -b) return -b;
      return v;
    endfunction

    function logic [30:0] abs31(longint v);
      longint m;
      m = v < 0 ? -v : v;
      return m > WMAX ? 31'h7FFF_FFFF : m[30:0];
    endfunction

    function void note(sensor_word_t w);
      longint ms, rate, target, err, deriv, drive, yerr, turn, dc, r, l;
      drive_word_t d;
      ms = (w.elapsed_ms == 10'd0) ? longint'(1) : longint'(w.elapsed_ms);
      rate = sat(longint'(w.pitch_rate) - gains[REG_PITCH_BIAS]);
      rate = divr(rate * ms, 1000);
      tilt = blend(sat(tilt + rate), W98, w.accel_tilt, W02);
      target = sat(mulshr(gains[REG_SPEED_KP],
                   sat(longint'(w.target_speed) + w.wheel_speed), 20)
                   + gains[REG_TILT_OFS]);
      target = blend(target, W70, ptt, W30);
      ptt = target;
      err = sat(target - tilt);
      integ = clampu(sat(integ + divr(err * ms, 1000)), 300);
      deriv = divr(sat(err - perr) * 1000, ms);
      drive = sat(sat(mulshr(gains[REG_ANGLE_KP], err, 20)
                      + mulshr(gains[REG_ANGLE_KI], integ, 20))
                  + mulshr(gains[REG_ANGLE_KD], deriv, 20));
      drive = blend(drive, W70, pdrv, W30);
      pdrv = drive;
      perr = err;
      yerr = sat(longint'(w.target_yaw_rate) - sat(longint'(w.yaw_rate) - gains[REG_YAW_BIAS]));
      turn = blend(mulshr(gains[REG_TURN_KP], yerr, 20), W70, pturn, W30);
      pturn = turn;
      dc = clampu(drive, 120);
      r = sat(dc + turn);
      l = sat(dc - turn);
      d.right_accel = abs31(r);
      d.left_accel = abs31(l);
      d.right_reverse = r > 0;
      d.left_forward = l > 0;
      d.tilt_estimate = tilt[31:0];
      pending_drive.push_back(d);
    endfunction

    function void check(drive_word_t a);
      drive_word_t e;
      if (pending_drive.size() == 0) begin
        $display("%0t: drive word with none expected", $time);
        errors++;
        return;
      end
      e = pending_drive.pop_front();
      if (a.right_accel !== e.right_accel) begin
        $display("%0t: right_accel exp %h got %h", $time, e.right_accel, a.right_accel);
        errors++;
      end
      if (a.left_accel !== e.left_accel) begin
        $display("%0t: left_accel exp %h got %h", $time, e.left_accel, a.left_accel);
        errors++;
      end
      if (a.right_reverse !== e.right_reverse) begin
        $display("%0t: right_reverse exp %b got %b", $time, e.right_reverse, a.right_reverse);
        errors++;
      end
      if (a.left_forward !== e.left_forward) begin
        $display("%0t: left_forward exp %b got %b", $time, e.left_forward, a.left_forward);
        errors++;
      end
      if (a.tilt_estimate !== e.tilt_estimate) begin
        $display("%0t: tilt_estimate exp %h got %h", $time, e.tilt_estimate, a.tilt_estimate);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  cbpc_in_if in_if();
  cbpc_out_if out_if();

  cascaded_balance_pid_controller uut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_if), .out_chan(out_if),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  balance_scoreboard sb = new();
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_AW'(idx) << 2; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic send_word(sensor_word_t w);
    in_if.valid <= 1'b1;
    in_if.accel_tilt <= w.accel_tilt; in_if.pitch_rate <= w.pitch_rate;
    in_if.yaw_rate <= w.yaw_rate; in_if.wheel_speed <= w.wheel_speed;
    in_if.target_speed <= w.target_speed; in_if.target_yaw_rate <= w.target_yaw_rate;
    in_if.elapsed_ms <= w.elapsed_ms;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note(w);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Idle the input and let every outstanding drive word come back.
  task automatic drain();
    @(posedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending_drive.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_signal();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2: return $urandom;
      default: return $urandom_range(0, 1 << 19) - (1 << 18);
    endcase
  endfunction

  function automatic sensor_word_t rand_word();
    sensor_word_t w;
    w.accel_tilt = rand_signal(); w.pitch_rate = rand_signal();
    w.yaw_rate = rand_signal(); w.wheel_speed = rand_signal();
    w.target_speed = rand_signal(); w.target_yaw_rate = rand_signal();
    case ($urandom_range(0, 9))
      0: w.elapsed_ms = 10'd0;
      1: w.elapsed_ms = 10'($urandom_range(1000, 1023));
      2: w.elapsed_ms = 10'($urandom);
      default: w.elapsed_ms = 10'($urandom_range(1, 20));
    endcase
    return w;
  endfunction

  function automatic sensor_word_t fill_word(logic [31:0] v, logic [9:0] ms);
    sensor_word_t w;
    w.accel_tilt = v; w.pitch_rate = v; w.yaw_rate = v; w.wheel_speed = v;
    w.target_speed = v; w.target_yaw_rate = v; w.elapsed_ms = ms;
    return w;
  endfunction

  task automatic directed_words();
    sensor_word_t w;
    send_word(fill_word(32'h0, 10'd10));
    send_word(fill_word(32'h7FFF_FFFF, 10'd10));
    send_word(fill_word(32'h8000_0000, 10'd10));
    send_word(fill_word(32'h7FFF_FFFF, 10'd0));
    send_word(fill_word(32'h8000_0000, 10'd1000));
    send_word(fill_word(32'h0001_0000, 10'd1023));
    send_word(fill_word(32'hFFFF_FFFF, 10'd1));
    // Elapsed zero must behave as one millisecond.
    send_word(fill_word(32'h0000_8000, 10'd0));
    send_word(fill_word(32'h0000_8000, 10'd1));
    w = fill_word(32'h0, 10'd10); w.accel_tilt = 32'h7FFF_FFFF; send_word(w);
    w = fill_word(32'h0, 10'd10); w.pitch_rate = 32'h8000_0000; send_word(w);
    w = fill_word(32'h0, 10'd10); w.yaw_rate = 32'h7FFF_FFFF; send_word(w);
    w = fill_word(32'h0, 10'd10); w.target_yaw_rate = 32'h8000_0000; send_word(w);
    w = fill_word(32'h0, 10'd10);
    w.wheel_speed = 32'h7FFF_FFFF; w.target_speed = 32'h7FFF_FFFF; send_word(w);
    w = fill_word(32'h0, 10'd5);
    w.wheel_speed = 32'h8000_0000; w.target_speed = 32'h8000_0000; send_word(w);
    w = fill_word(32'h0002_0000, 10'd1023); w.yaw_rate = 32'hFFFE_0000; send_word(w);
    for (int i = 0; i < 4; i++) send_word(fill_word(32'h0, 10'd1));
  endtask

  task automatic load_regs(int mode);
    for (int i = 0; i < NUM_REGS; i++) begin
      case (mode)
        0: reg_write(3'(i), CFG_RESET[i]);
        1: reg_write(3'(i), 32'h7FFF_FFFF);
        2: reg_write(3'(i), 32'h8000_0000);
        3: reg_write(3'(i), 32'h0);
        default: reg_write(3'(i), $urandom_range(0, 1) ? rand_signal()
                                  : $urandom_range(0, 1 << 26) - (1 << 25));
      endcase
    end
  endtask

  // Receiver: random back-pressure bursts plus one long hold on request.
  initial begin
    int idle_cnt, hold_cnt;
    drive_word_t a;
    idle_cnt = 0; hold_cnt = 0;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_if.valid && out_if.ready) begin
        a.right_accel = out_if.right_accel; a.left_accel = out_if.left_accel;
        a.right_reverse = out_if.right_reverse; a.left_forward = out_if.left_forward;
        a.tilt_estimate = out_if.tilt_estimate;
        sb.check(a);
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 3000;
        out_if.ready <= 1'b0;
      end else if (idle_cnt > 0) begin
        idle_cnt--;
        out_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        idle_cnt = $urandom_range(0, 8);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // Watchdog on cycles without any word moving.
  initial begin
    forever begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= 20000) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    cfg_paddr <= '0; cfg_pwdata <= '0;
    in_if.valid <= 1'b0;
    in_if.accel_tilt <= '0; in_if.pitch_rate <= '0; in_if.yaw_rate <= '0;
    in_if.wheel_speed <= '0; in_if.target_speed <= '0; in_if.target_yaw_rate <= '0;
    in_if.elapsed_ms <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_words();
    for (int i = 0; i < 200; i++) send_word(rand_word());
    drain();

    // Settings: random, top extreme, bottom extreme, zero, random, defaults.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: load_regs(4);
        1: load_regs(1);
        2: load_regs(2);
        3: load_regs(3);
        4: load_regs(4);
        default: load_regs(0);
      endcase
      if (phase == 5) quiet = 1'b1;
      for (int i = 0; i < 190; i++) begin
        if (phase == 4 && i == 50) hold_req = 1'b1;
        send_word(rand_word());
      end
      drain();
    end

    repeat (1000) @(posedge clk);
    if (sb.errors == 0 && sb.pending_drive.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
